// ===== hdl/npc_pkg.sv =====
// Shared types, constants and distance function for the nearest palette color block.
package npc_pkg;

    localparam int PALETTE_DEPTH_DEFAULT = 64;
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int SIZE_W  = 9;
    localparam int DIST_W  = 18;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Item traveling down the cell chain, with the best match found so far.
    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] slot;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [INDEX_W-1:0] best_idx;
        logic [DIST_W-1:0]  best_dist;
        logic [COLOR_W-1:0] best_blue;
        logic [COLOR_W-1:0] best_green;
        logic [COLOR_W-1:0] best_red;
    } t_item;

    // Squared difference of two color components.
    function automatic logic [2*COLOR_W-1:0] sq_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (2*COLOR_W)'(d) * (2*COLOR_W)'(d);
    endfunction

endpackage

// ===== hdl/npc_if.sv =====
// Channel interfaces for pixel input, result output and configuration writes.
interface npc_pix_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] entry_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, operation, entry_index, blue, green, red, input ready);
    modport sink   (input valid, operation, entry_index, blue, green, red, output ready);
endinterface

interface npc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] best_index;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    modport source (output valid, best_index, out_blue, out_green, out_red, input ready);
    modport sink   (input valid, best_index, out_blue, out_green, out_red, output ready);
endinterface

interface npc_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] palette_size;
    modport source (output valid, palette_size, input ready);
    modport sink   (input valid, palette_size, output ready);
endinterface

// ===== hdl/npc_cell.sv =====
// One palette entry with its distance stage and compare stage.
module npc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [npc_pkg::SIZE_W-1:0] i_size,
    input  logic                  i_valid,
    input  npc_pkg::t_item        i_item,
    output logic                  o_valid,
    output npc_pkg::t_item        o_item
);
    import npc_pkg::*;

    logic [COLOR_W-1:0] r_entry_blue, r_entry_green, r_entry_red;
    logic               r_a_valid, r_b_valid;
    t_item              r_a_item, r_b_item, n_b_item;
    logic [DIST_W-1:0]  r_a_dist, n_a_dist;
    logic [COLOR_W-1:0] r_a_blue, r_a_green, r_a_red;
    logic               w_active;

    // Load items write this entry as they pass through.
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && i_item.op == OP_LOAD && i_item.slot == INDEX_W'(CELL_INDEX)) begin
            r_entry_blue  <= i_item.blue;
            r_entry_green <= i_item.green;
            r_entry_red   <= i_item.red;
        end
    end

    // Distance from the item color to the stored entry.
    always_comb begin
        n_a_dist = DIST_W'(sq_diff(i_item.blue, r_entry_blue))
                 + DIST_W'(sq_diff(i_item.green, r_entry_green))
                 + DIST_W'(sq_diff(i_item.red, r_entry_red));
    end

    // Only entries below the configured size take part; entry zero always does.
    assign w_active = (CELL_INDEX == 0) || (i_size > SIZE_W'(CELL_INDEX));

    // Keep the earlier best on ties so the lowest index wins.
    always_comb begin
        n_b_item = r_a_item;
        if (r_a_item.op == OP_PIXEL && w_active &&
            (CELL_INDEX == 0 || r_a_dist < r_a_item.best_dist)) begin
            n_b_item.best_idx   = INDEX_W'(CELL_INDEX);
            n_b_item.best_dist  = r_a_dist;
            n_b_item.best_blue  = r_a_blue;
            n_b_item.best_green = r_a_green;
            n_b_item.best_red   = r_a_red;
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item  <= i_item;
            r_a_dist  <= n_a_dist;
            r_a_blue  <= r_entry_blue;
            r_a_green <= r_entry_green;
            r_a_red   <= r_entry_red;
            r_b_item  <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;
endmodule

// ===== hdl/nearest_palette_color.sv =====
// Top level: configuration register, chain of palette cells and output register.
//
// Use: palette entries are loaded through i_pix with operation 0 and entry_index
// naming the slot; loads to slots at or above PALETTE_DEPTH are dropped. Pixels
// are sent with operation 1 and produce one result on o_res: the index of the
// nearest entry among the first palette_size entries (lowest index on ties) and
// that entry's color. Loads produce no result. A pixel must only search entries
// that were loaded earlier. palette_size is written through i_cfg while idle.
// Throughput: one item per cycle while the receiver does not stall, loads and pixels mixed freely.
// The path from input transfer to a valid result runs through two register
// stages per palette cell (distance, then compare) plus the output register,
// the first stage being loaded at the input transfer edge. Items travel the
// chain in order, so a load affects exactly the pixels behind it.
// Reset clears all valid bits and sets palette_size to 1; palette contents are
// undefined until loaded. When the receiver stalls a waiting result, the whole
// chain holds and i_pix.ready drops; nothing is lost or repeated.
module nearest_palette_color #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    npc_cfg_if.sink      i_cfg,
    npc_pix_if.sink      i_pix,
    npc_res_if.source    o_res
);
    import npc_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic              w_en;
    logic              w_valid [PALETTE_DEPTH+1];
    t_item             w_item  [PALETTE_DEPTH+1];
    logic              r_out_valid;
    t_item             r_out_item;

    // Configuration register.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(1);
        end else if (i_cfg.valid) begin
            r_size <= i_cfg.palette_size;
        end
    end

    // The chain advances whenever the output register can take a transfer.
    assign w_en = !r_out_valid || o_res.ready;
    assign i_pix.ready = w_en;

    // Chain input.
    always_comb begin
        w_valid[0]            = i_pix.valid;
        w_item[0]             = '0;
        w_item[0].op          = i_pix.operation;
        w_item[0].slot        = i_pix.entry_index;
        w_item[0].blue        = i_pix.blue;
        w_item[0].green       = i_pix.green;
        w_item[0].red         = i_pix.red;
    end

    // One cell per palette entry.
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        npc_cell #(.CELL_INDEX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_size  (r_size),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Output register: only pixel items leave as results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[PALETTE_DEPTH] && w_item[PALETTE_DEPTH].op == OP_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item <= w_item[PALETTE_DEPTH];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.best_index = r_out_item.best_idx;
    assign o_res.out_blue   = r_out_item.best_blue;
    assign o_res.out_green  = r_out_item.best_green;
    assign o_res.out_red    = r_out_item.best_red;

    // A result never names an entry beyond the stored palette.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (32'(o_res.best_index) < PALETTE_DEPTH))
        else $error("result index beyond palette depth");

    // The chain stalls exactly when a held result is refused.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_pix.ready)
        else $error("input taken while result stalled");

    // Reset leaves a palette size of one.
    a_size_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_size == SIZE_W'(1)))
        else $error("palette size not one after reset");
endmodule
